### rtl/rope_pkg.sv
// Shared constants and elaboration-time coefficient functions for the rotary embedding core.
package rope_pkg;

    localparam int MANT_STEPS = 24;
    localparam int ROT_STEPS  = 16;
    localparam int PADDR_W    = 3;

    localparam logic [21:0] LOG2_BASE_RST      = 22'd870829;
    localparam logic [3:0]  HEAD_SIZE_LOG2_RST = 4'd7;
    localparam logic [29:0] INV_TWO_PI_Q32     = 30'd683565276;
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
    localparam logic signed [31:0] NEG_ONE_Q30 = -32'sd1073741824;

    // Register indexes, taken from the word address of the APB port.
    localparam logic REG_LOG2_BASE      = 1'b0;
    localparam logic REG_HEAD_SIZE_LOG2 = 1'b1;

    function automatic logic [63:0] rope_isqrt(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int it = 0; it < 32; it++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Restoring long division, used only for constant tables.
    function automatic logic [63:0] rope_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int bi = 63; bi >= 0; bi--) begin
            rem = {rem[63:0], num[bi]};
            if (rem >= {1'b0, den}) begin
                rem   = rem - {1'b0, den};
                q[bi] = 1'b1;
            end
        end
        return q;
    endfunction

    // Multiplier for 2^-(2^-k) in Q32.
    function automatic logic [31:0] rope_pow_coef(input int k);
        logic [63:0] t;
        t = rope_isqrt(64'h8000_0000_0000_0000);
        for (int j = 1; j < k; j++) begin
            t = rope_isqrt(t << 32);
        end
        return t[31:0];
    endfunction

    // Cosine and sine of pi/2^(j+2) in Q30, packed as {cos, sin}.
    function automatic logic [63:0] rope_rot_coef(input int j);
        logic [63:0] tc;
        logic [63:0] ts;
        logic [63:0] nc;
        tc = rope_isqrt(64'h0800_0000_0000_0000);
        ts = tc;
        for (int q = 1; q <= j; q++) begin
            nc = rope_isqrt(((64'h4000_0000 + tc) >> 1) << 30);
            ts = rope_udiv(ts << 30, nc << 1);
            tc = nc;
        end
        return {tc[31:0], ts[31:0]};
    endfunction

endpackage

### rtl/rope_in_if.sv
// Input stream channel: one token position, pair index and query/key pair per beat.
interface rope_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic [15:0]                    position;
    logic [6:0]                     pair_index;
    logic signed [SAMPLE_WIDTH-1:0] query_real;
    logic signed [SAMPLE_WIDTH-1:0] query_imag;
    logic signed [SAMPLE_WIDTH-1:0] key_real;
    logic signed [SAMPLE_WIDTH-1:0] key_imag;

    modport source (
        output valid, position, pair_index, query_real, query_imag, key_real, key_imag,
        input  ready
    );
    modport sink (
        input  valid, position, pair_index, query_real, query_imag, key_real, key_imag,
        output ready
    );
endinterface

### rtl/rope_out_if.sv
// Output stream channel: rotated query/key pair and error flag per beat.
interface rope_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] query_real_out;
    logic signed [SAMPLE_WIDTH-1:0] query_imag_out;
    logic signed [SAMPLE_WIDTH-1:0] key_real_out;
    logic signed [SAMPLE_WIDTH-1:0] key_imag_out;
    logic                           index_error;

    modport source (
        output valid, query_real_out, query_imag_out, key_real_out, key_imag_out, index_error,
        input  ready
    );
    modport sink (
        input  valid, query_real_out, query_imag_out, key_real_out, key_imag_out, index_error,
        output ready
    );
endinterface

### rtl/rotary_position_embedding_core.sv
// Top level of the rotary position embedding core: registers, pipelines and stream handshake.
//
// Usage: each beat on i_item carries a token position, a pair index and one
// query pair and one key pair (signed, SAMPLE_WIDTH bits). Each accepted beat
// produces exactly one beat on o_result with both pairs rotated by the angle
// position * base^(-2*pair_index/head_size), or passed unchanged with
// index_error set when the pair lies outside the head or the head exceeds MAX_HEAD_SIZE.
// Configuration (log2_base at address 0, head_size_log2 at address 4) is
// written over the APB port while the stream is idle.
// An accepted beat passes through the phase pipeline (exponent stage, one per
// mantissa multiply, then frequency, product and shift), the sine/cosine
// pipeline (quarter-turn select, one per table rotation) and the final rotation.
// One beat per cycle unless the receiver stalls; the whole pipeline advances together.
// When the receiver stalls with a result waiting, the whole pipeline freezes,
// bubbles included, and i_item.ready drops; no beat is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
module rotary_position_embedding_core
    import rope_pkg::*;
#(
    parameter int MAX_HEAD_SIZE = 256,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rope_in_if.sink            i_item,
    rope_out_if.source         o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int SW4 = 4 * SAMPLE_WIDTH;

    logic [21:0] log2_base;
    logic [3:0]  head_size_log2;
    logic        en;

    rope_apb_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_log2_base      (log2_base),
        .o_head_size_log2 (head_size_log2)
    );

    assign en           = !o_result.valid || o_result.ready;
    assign i_item.ready = en;

    logic [SW4-1:0] in_samples;
    assign in_samples = {i_item.key_imag, i_item.key_real, i_item.query_imag, i_item.query_real};

    logic           ph_v, ph_err;
    logic [17:0]    ph_idx;
    logic [SW4-1:0] ph_smp;

    rope_phase #(
        .MAX_HEAD_SIZE (MAX_HEAD_SIZE),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_phase (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (i_item.valid),
        .i_position       (i_item.position),
        .i_pair_index     (i_item.pair_index),
        .i_samples        (in_samples),
        .i_log2_base      (log2_base),
        .i_head_size_log2 (head_size_log2),
        .o_valid          (ph_v),
        .o_err            (ph_err),
        .o_idx            (ph_idx),
        .o_samples        (ph_smp)
    );

    logic               sc_v, sc_err;
    logic signed [31:0] sc_cos, sc_sin;
    logic [SW4-1:0]     sc_smp;

    rope_sincos #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_sincos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (ph_v),
        .i_err     (ph_err),
        .i_idx     (ph_idx),
        .i_samples (ph_smp),
        .o_valid   (sc_v),
        .o_err     (sc_err),
        .o_cos     (sc_cos),
        .o_sin     (sc_sin),
        .o_samples (sc_smp)
    );

    rope_rotate #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_rotate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (sc_v),
        .i_err        (sc_err),
        .i_cos        (sc_cos),
        .i_sin        (sc_sin),
        .i_samples    (sc_smp),
        .o_valid      (o_result.valid),
        .o_err        (o_result.index_error),
        .o_query_real (o_result.query_real_out),
        .o_query_imag (o_result.query_imag_out),
        .o_key_real   (o_result.key_real_out),
        .o_key_imag   (o_result.key_imag_out)
    );
endmodule

### rtl/rope_apb_regs.sv
// APB configuration registers: log2 of the rotation base and log2 of the head size.
module rope_apb_regs
    import rope_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [21:0]        o_log2_base,
    output logic [3:0]         o_head_size_log2
);
    logic [21:0] r_log2_base;
    logic [3:0]  r_head_size_log2;
    logic        reg_sel;

    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_base      <= LOG2_BASE_RST;
            r_head_size_log2 <= HEAD_SIZE_LOG2_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_LOG2_BASE:      r_log2_base      <= pwdata[21:0];
                REG_HEAD_SIZE_LOG2: r_head_size_log2 <= pwdata[3:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_LOG2_BASE:      prdata = {10'd0, r_log2_base};
            REG_HEAD_SIZE_LOG2: prdata = {28'd0, r_head_size_log2};
        endcase
    end

    assign o_log2_base      = r_log2_base;
    assign o_head_size_log2 = r_head_size_log2;
endmodule

### rtl/rope_phase.sv
// Phase pipeline: exponent, 2^-f mantissa chain, frequency scaling and angle in turns.
module rope_phase
    import rope_pkg::*;
#(
    parameter int MAX_HEAD_SIZE = 256,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [15:0]               i_position,
    input  logic [6:0]                i_pair_index,
    input  logic [4*SAMPLE_WIDTH-1:0] i_samples,
    input  logic [21:0]               i_log2_base,
    input  logic [3:0]                i_head_size_log2,
    output logic                      o_valid,
    output logic                      o_err,
    output logic [17:0]               o_idx,
    output logic [4*SAMPLE_WIDTH-1:0] o_samples
);
    localparam int SW4 = 4 * SAMPLE_WIDTH;

    // Mantissa chain: index 0 is the exponent stage.
    logic           r_v   [0:MANT_STEPS];
    logic           r_err [0:MANT_STEPS];
    logic [15:0]    r_p   [0:MANT_STEPS];
    logic [13:0]    r_n   [0:MANT_STEPS];
    logic [23:0]    r_f   [0:MANT_STEPS];
    logic [32:0]    r_m   [0:MANT_STEPS];
    logic [SW4-1:0] r_smp [0:MANT_STEPS];

    logic [15:0] head;
    logic        n_err;
    logic [37:0] n_e;

    assign head  = 16'd1 << i_head_size_log2;
    assign n_err = ({8'd0, i_pair_index, 1'b0} >= head) ||
                   ({1'b0, head} > 17'(MAX_HEAD_SIZE));
    assign n_e   = ((38'(i_log2_base) * 38'(i_pair_index)) << 9) >> i_head_size_log2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0]   <= i_valid;
            r_err[0] <= n_err;
            r_p[0]   <= i_position;
            r_n[0]   <= n_e[37:24];
            r_f[0]   <= n_e[23:0];
            r_m[0]   <= 33'h1_0000_0000;
            r_smp[0] <= i_samples;
        end
    end

    for (genvar k = 1; k <= MANT_STEPS; k++) begin : g_mant
        localparam logic [31:0] TK = rope_pow_coef(k);
        logic [64:0] prod;
        assign prod = 65'(r_m[k-1]) * 65'(TK) + 65'h8000_0000;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k]   <= r_v[k-1];
                r_err[k] <= r_err[k-1];
                r_p[k]   <= r_p[k-1];
                r_n[k]   <= r_n[k-1];
                r_f[k]   <= r_f[k-1];
                r_m[k]   <= r_f[k-1][MANT_STEPS-k] ? prod[64:32] : r_m[k-1];
                r_smp[k] <= r_smp[k-1];
            end
        end
    end

    // Frequency in turns per position, then position times frequency, then the shift by n.
    logic           r_c_v, r_c_err;
    logic [15:0]    r_c_p;
    logic [13:0]    r_c_n;
    logic [29:0]    r_c;
    logic [SW4-1:0] r_c_smp;
    logic           r_d_v, r_d_err;
    logic [13:0]    r_d_n;
    logic [45:0]    r_pc;
    logic [SW4-1:0] r_d_smp;
    logic           r_e_v, r_e_err;
    logic [17:0]    r_idx;
    logic [SW4-1:0] r_e_smp;

    logic [62:0] c_prod;
    logic [45:0] pc_shift;

    assign c_prod   = 63'(r_m[MANT_STEPS]) * 63'(INV_TWO_PI_Q32) + 63'h8000_0000;
    assign pc_shift = (|r_d_n[13:6]) ? 46'd0 : (r_pc >> r_d_n[5:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (i_en) begin
            r_c_v   <= r_v[MANT_STEPS];
            r_c_err <= r_err[MANT_STEPS];
            r_c_p   <= r_p[MANT_STEPS];
            r_c_n   <= r_n[MANT_STEPS];
            r_c     <= c_prod[61:32];
            r_c_smp <= r_smp[MANT_STEPS];

            r_d_v   <= r_c_v;
            r_d_err <= r_c_err;
            r_d_n   <= r_c_n;
            r_pc    <= 46'(r_c_p) * 46'(r_c);
            r_d_smp <= r_c_smp;

            r_e_v   <= r_d_v;
            r_e_err <= r_d_err;
            r_idx   <= pc_shift[31:14];
            r_e_smp <= r_d_smp;
        end
    end

    assign o_valid   = r_e_v;
    assign o_err     = r_e_err;
    assign o_idx     = r_idx;
    assign o_samples = r_e_smp;
endmodule

### rtl/rope_sincos.sv
// Sine/cosine pipeline: quarter-turn select, then one table rotation per phase bit.
module rope_sincos
    import rope_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic                      i_err,
    input  logic [17:0]               i_idx,
    input  logic [4*SAMPLE_WIDTH-1:0] i_samples,
    output logic                      o_valid,
    output logic                      o_err,
    output logic signed [31:0]        o_cos,
    output logic signed [31:0]        o_sin,
    output logic [4*SAMPLE_WIDTH-1:0] o_samples
);
    localparam int SW4 = 4 * SAMPLE_WIDTH;

    logic               r_v   [0:ROT_STEPS];
    logic               r_err [0:ROT_STEPS];
    logic [15:0]        r_idx [0:ROT_STEPS];
    logic signed [31:0] r_c   [0:ROT_STEPS];
    logic signed [31:0] r_s   [0:ROT_STEPS];
    logic [SW4-1:0]     r_smp [0:ROT_STEPS];

    logic signed [31:0] n_c0, n_s0;

    always_comb begin
        unique case (i_idx[17:16])
            2'd0: begin n_c0 = ONE_Q30;     n_s0 = '0;          end
            2'd1: begin n_c0 = '0;          n_s0 = ONE_Q30;     end
            2'd2: begin n_c0 = NEG_ONE_Q30; n_s0 = '0;          end
            2'd3: begin n_c0 = '0;          n_s0 = NEG_ONE_Q30; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0]   <= i_valid;
            r_err[0] <= i_err;
            r_idx[0] <= i_idx[15:0];
            r_c[0]   <= n_c0;
            r_s[0]   <= n_s0;
            r_smp[0] <= i_samples;
        end
    end

    for (genvar j = 0; j < ROT_STEPS; j++) begin : g_rot
        localparam logic [63:0] CS = rope_rot_coef(j);
        localparam logic signed [31:0] COS_J = CS[63:32];
        localparam logic signed [31:0] SIN_J = CS[31:0];
        logic signed [63:0] xc, ys, xs, yc, sum_x, sum_y;
        assign xc    = 64'(r_c[j]) * 64'(COS_J);
        assign ys    = 64'(r_s[j]) * 64'(SIN_J);
        assign xs    = 64'(r_c[j]) * 64'(SIN_J);
        assign yc    = 64'(r_s[j]) * 64'(COS_J);
        assign sum_x = (xc - ys + 64'sd536870912) >>> 30;
        assign sum_y = (xs + yc + 64'sd536870912) >>> 30;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1]   <= r_v[j];
                r_err[j+1] <= r_err[j];
                r_idx[j+1] <= r_idx[j];
                r_smp[j+1] <= r_smp[j];
                if (r_idx[j][ROT_STEPS-1-j]) begin
                    r_c[j+1] <= sum_x[31:0];
                    r_s[j+1] <= sum_y[31:0];
                end else begin
                    r_c[j+1] <= r_c[j];
                    r_s[j+1] <= r_s[j];
                end
            end
        end
    end

    assign o_valid   = r_v[ROT_STEPS];
    assign o_err     = r_err[ROT_STEPS];
    assign o_cos     = r_c[ROT_STEPS];
    assign o_sin     = r_s[ROT_STEPS];
    assign o_samples = r_smp[ROT_STEPS];
endmodule

### rtl/rope_rotate.sv
// Final rotation of the query and key pairs with rounding, saturation and error bypass.
module rope_rotate
    import rope_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic                           i_err,
    input  logic signed [31:0]             i_cos,
    input  logic signed [31:0]             i_sin,
    input  logic [4*SAMPLE_WIDTH-1:0]      i_samples,
    output logic                           o_valid,
    output logic                           o_err,
    output logic signed [SAMPLE_WIDTH-1:0] o_query_real,
    output logic signed [SAMPLE_WIDTH-1:0] o_query_imag,
    output logic signed [SAMPLE_WIDTH-1:0] o_key_real,
    output logic signed [SAMPLE_WIDTH-1:0] o_key_imag
);
    localparam int SW  = SAMPLE_WIDTH;
    localparam int PW  = SW + 32;
    localparam int AW  = SW + 33;
    localparam logic signed [AW-1:0] SAT_HI = {{34{1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{34{1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [AW-1:0] HALF   = AW'(64'd536870912);

    function automatic logic signed [SW-1:0] round_sat(input logic signed [PW-1:0] a,
                                                       input logic signed [PW-1:0] b,
                                                       input logic             sub);
        logic signed [AW-1:0] sum;
        logic signed [AW-1:0] sh;
        sum = sub ? (AW'(a) - AW'(b) + HALF) : (AW'(a) + AW'(b) + HALF);
        sh  = sum >>> 30;
        if (sh > SAT_HI) begin
            return SAT_HI[SW-1:0];
        end else if (sh < SAT_LO) begin
            return SAT_LO[SW-1:0];
        end
        return sh[SW-1:0];
    endfunction

    logic signed [SW-1:0] qr, qi, kr, ki;
    assign qr = i_samples[0*SW +: SW];
    assign qi = i_samples[1*SW +: SW];
    assign kr = i_samples[2*SW +: SW];
    assign ki = i_samples[3*SW +: SW];

    logic                 r_m_v, r_m_err;
    logic signed [PW-1:0] r_prod [0:7];
    logic signed [SW-1:0] r_qr, r_qi, r_kr, r_ki;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (i_en) begin
            r_m_v     <= i_valid;
            r_m_err   <= i_err;
            r_prod[0] <= PW'(qr) * PW'(i_cos);
            r_prod[1] <= PW'(qi) * PW'(i_sin);
            r_prod[2] <= PW'(qr) * PW'(i_sin);
            r_prod[3] <= PW'(qi) * PW'(i_cos);
            r_prod[4] <= PW'(kr) * PW'(i_cos);
            r_prod[5] <= PW'(ki) * PW'(i_sin);
            r_prod[6] <= PW'(kr) * PW'(i_sin);
            r_prod[7] <= PW'(ki) * PW'(i_cos);
            r_qr      <= qr;
            r_qi      <= qi;
            r_kr      <= kr;
            r_ki      <= ki;
        end
    end

    logic                 r_o_v, r_o_err;
    logic signed [SW-1:0] r_o_qr, r_o_qi, r_o_kr, r_o_ki;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_o_v   <= r_m_v;
            r_o_err <= r_m_err;
            // An out-of-range pair leaves the samples untouched.
            if (r_m_err) begin
                r_o_qr <= r_qr;
                r_o_qi <= r_qi;
                r_o_kr <= r_kr;
                r_o_ki <= r_ki;
            end else begin
                r_o_qr <= round_sat(r_prod[0], r_prod[1], 1'b1);
                r_o_qi <= round_sat(r_prod[2], r_prod[3], 1'b0);
                r_o_kr <= round_sat(r_prod[4], r_prod[5], 1'b1);
                r_o_ki <= round_sat(r_prod[6], r_prod[7], 1'b0);
            end
        end
    end

    assign o_valid      = r_o_v;
    assign o_err        = r_o_err;
    assign o_query_real = r_o_qr;
    assign o_query_imag = r_o_qi;
    assign o_key_real   = r_o_kr;
    assign o_key_imag   = r_o_ki;
endmodule
